FILE: rtl/srm_pkg.sv
`default_nettype none

package srm_pkg;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_Q_LEV,
        ST_Q_TBL,
        ST_Q_VAL,
        ST_Q_CMP,
        ST_B_INIT,
        ST_B_TBL,
        ST_B_VAL,
        ST_B_CMP
    } srm_state_t;

    typedef struct packed {
        logic load;
        logic q_cap;
        logic q_lev;
        logic tbl_rd;
        logic bld_sel;
        logic val_rd;
        logic out_load;
        logic bld_init;
        logic bld_wr;
        logic bld_done;
    } srm_cmd_t;

    typedef struct packed {
        logic q_err;
        logic rsp_free;
        logic one_elem;
        logic row_last;
        logic lev_last;
    } srm_sts_t;

endpackage

`default_nettype wire

FILE: rtl/srm_req_if.sv
`default_nettype none

interface srm_req_if #(
    parameter int IDX_W       = 10,
    parameter int VALUE_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last_element;
    logic        [IDX_W-1:0]       range_lo;
    logic        [IDX_W-1:0]       range_hi;

    modport source (
        output valid, req_type, value, last_element, range_lo, range_hi,
        input  ready
    );

    modport sink (
        input  valid, req_type, value, last_element, range_lo, range_hi,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/srm_rsp_if.sv
`default_nettype none

interface srm_rsp_if #(
    parameter int IDX_W = 10
) ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] max_index;
    logic             range_error;

    modport source (
        output valid, max_index, range_error,
        input  ready
    );

    modport sink (
        input  valid, max_index, range_error,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/srm_ctrl.sv
`default_nettype none

module srm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_type,
    input  wire logic              req_last,
    output logic                   req_ready,
    input  wire srm_pkg::srm_sts_t sts,
    output srm_pkg::srm_cmd_t      cmd
);

    srm_pkg::srm_state_t state_reg;
    srm_pkg::srm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            srm_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_type == srm_pkg::REQ_QUERY)
                    begin
                        cmd.q_cap  = 1'b1;
                        state_next = srm_pkg::ST_Q_LEV;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        if (req_last)
                        begin
                            state_next = srm_pkg::ST_B_INIT;
                        end
                    end
                end
            end
            srm_pkg::ST_Q_LEV:
            begin
                cmd.q_lev  = 1'b1;
                state_next = sts.q_err ? srm_pkg::ST_Q_CMP : srm_pkg::ST_Q_TBL;
            end
            srm_pkg::ST_Q_TBL:
            begin
                cmd.tbl_rd = 1'b1;
                state_next = srm_pkg::ST_Q_VAL;
            end
            srm_pkg::ST_Q_VAL:
            begin
                cmd.val_rd = 1'b1;
                state_next = srm_pkg::ST_Q_CMP;
            end
            srm_pkg::ST_Q_CMP:
            begin
                if (sts.rsp_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = srm_pkg::ST_IDLE;
                end
            end
            srm_pkg::ST_B_INIT:
            begin
                cmd.bld_init = 1'b1;
                if (sts.one_elem)
                begin
                    cmd.bld_done = 1'b1;
                    state_next   = srm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = srm_pkg::ST_B_TBL;
                end
            end
            srm_pkg::ST_B_TBL:
            begin
                cmd.tbl_rd  = 1'b1;
                cmd.bld_sel = 1'b1;
                state_next  = srm_pkg::ST_B_VAL;
            end
            srm_pkg::ST_B_VAL:
            begin
                cmd.val_rd = 1'b1;
                state_next = srm_pkg::ST_B_CMP;
            end
            srm_pkg::ST_B_CMP:
            begin
                cmd.bld_wr = 1'b1;
                if (sts.row_last && sts.lev_last)
                begin
                    cmd.bld_done = 1'b1;
                    state_next   = srm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = srm_pkg::ST_B_TBL;
                end
            end
            default:
            begin
                state_next = srm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/srm_dpath.sv
`default_nettype none

module srm_dpath #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_WIDTH  = 32,
    localparam int IDX_W       = $clog2(MAX_ELEMENTS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire srm_pkg::srm_cmd_t             cmd,
    output srm_pkg::srm_sts_t                  sts,
    input  wire logic signed [VALUE_WIDTH-1:0] req_value,
    input  wire logic        [IDX_W-1:0]       req_lo,
    input  wire logic        [IDX_W-1:0]       req_hi,
    input  wire logic                          rsp_ready,
    output logic                               rsp_valid,
    output logic             [IDX_W-1:0]       rsp_max_index,
    output logic                               rsp_range_error
);

    localparam int CNT_W     = IDX_W + 1;
    localparam int SUM_W     = IDX_W + 2;
    localparam int LEVELS    = IDX_W + 1;
    localparam int LEV_W     = $clog2(LEVELS);
    localparam int TA_W      = LEV_W + IDX_W;
    localparam int TBL_DEPTH = LEVELS * (2 ** IDX_W);

    logic signed [VALUE_WIDTH-1:0] elem_mem [MAX_ELEMENTS];
    logic        [IDX_W-1:0]       tbl_mem  [TBL_DEPTH];

    logic [CNT_W-1:0]              cnt_reg;
    logic                          rdy_reg;
    logic [IDX_W-1:0]              lo_reg;
    logic [IDX_W-1:0]              hi_reg;
    logic [LEV_W-1:0]              qlev_reg;
    logic                          err_reg;
    logic [LEV_W-1:0]              blev_reg;
    logic [IDX_W-1:0]              bidx_reg;
    logic [IDX_W-1:0]              ta_reg;
    logic [IDX_W-1:0]              tb_reg;
    logic signed [VALUE_WIDTH-1:0] va_reg;
    logic signed [VALUE_WIDTH-1:0] vb_reg;
    logic                          out_valid_reg;
    logic [IDX_W-1:0]              out_idx_reg;
    logic                          out_err_reg;

    logic [CNT_W-1:0] cnt_base;
    logic             has_room;
    logic [IDX_W-1:0] wr_idx;
    logic             elem_we;
    logic             tbl_we;
    logic [TA_W-1:0]  tbl_waddr;
    logic [IDX_W-1:0] tbl_wdata;
    logic [IDX_W-1:0] best_idx;
    logic [CNT_W-1:0] q_len;
    logic [LEV_W-1:0] q_lev;
    logic [CNT_W-1:0] q_pow;
    logic [CNT_W-1:0] q_b;
    logic [LEV_W-1:0] blev_m1;
    logic [CNT_W-1:0] b_half;
    logic [CNT_W-1:0] b_idx2;
    logic [SUM_W-1:0] b_span;
    logic [SUM_W-1:0] b_end;
    logic [LEV_W:0]   b_nl;
    logic [TA_W-1:0]  rd_addr_a;
    logic [TA_W-1:0]  rd_addr_b;

    // a load after a finished build starts a new array
    assign cnt_base = rdy_reg ? '0 : cnt_reg;
    assign has_room = cnt_base < CNT_W'(MAX_ELEMENTS);
    assign wr_idx   = cnt_base[IDX_W-1:0];
    assign elem_we  = cmd.load && has_room;

    // strict compare, ties go to the later window
    assign best_idx = (va_reg > vb_reg) ? ta_reg : tb_reg;

    assign tbl_we    = elem_we || cmd.bld_wr;
    assign tbl_waddr = cmd.bld_wr ? {blev_reg, bidx_reg} : {LEV_W'(0), wr_idx};
    assign tbl_wdata = cmd.bld_wr ? best_idx : wr_idx;

    // query level: floor log2 of the range length
    assign q_len = {1'b0, hi_reg} - {1'b0, lo_reg} + CNT_W'(1);

    always_comb
    begin
        q_lev = '0;
        for (int k = 0; k < CNT_W; k++)
        begin
            if (q_len[k])
            begin
                q_lev = LEV_W'(k);
            end
        end
    end

    assign q_pow = CNT_W'(1) << qlev_reg;
    assign q_b   = {1'b0, hi_reg} + CNT_W'(1) - q_pow;

    assign blev_m1 = blev_reg - LEV_W'(1);
    assign b_half  = CNT_W'(1) << blev_m1;
    assign b_idx2  = {1'b0, bidx_reg} + b_half;
    assign b_span  = SUM_W'(1) << blev_reg;
    assign b_end   = SUM_W'(bidx_reg) + SUM_W'(1) + b_span;
    assign b_nl    = {1'b0, blev_reg} + (LEV_W + 1)'(1);

    assign rd_addr_a = cmd.bld_sel ? {blev_m1, bidx_reg} : {qlev_reg, lo_reg};
    assign rd_addr_b = cmd.bld_sel ? {blev_m1, b_idx2[IDX_W-1:0]}
                                   : {qlev_reg, q_b[IDX_W-1:0]};

    always_comb
    begin
        sts          = '0;
        sts.q_err    = !rdy_reg || (lo_reg > hi_reg) || ({1'b0, hi_reg} >= cnt_reg);
        sts.rsp_free = !out_valid_reg || rsp_ready;
        sts.one_elem = cnt_reg < CNT_W'(2);
        sts.row_last = b_end > SUM_W'(cnt_reg);
        sts.lev_last = (cnt_reg >> b_nl) == '0;
    end

    // element store
    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[wr_idx] <= req_value;
        end
        if (cmd.val_rd)
        begin
            va_reg <= elem_mem[ta_reg];
            vb_reg <= elem_mem[tb_reg];
        end
    end

    // index table, one row of 2**IDX_W entries per level
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (cmd.tbl_rd)
        begin
            ta_reg <= tbl_mem[rd_addr_a];
            tb_reg <= tbl_mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_cap)
        begin
            lo_reg <= req_lo;
            hi_reg <= req_hi;
        end
        if (cmd.q_lev)
        begin
            qlev_reg <= q_lev;
            err_reg  <= sts.q_err;
        end
        if (cmd.out_load)
        begin
            out_idx_reg <= err_reg ? '0 : best_idx;
            out_err_reg <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rdy_reg       <= 1'b0;
            blev_reg      <= '0;
            bidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rdy_reg <= 1'b0;
                cnt_reg <= has_room ? cnt_base + CNT_W'(1) : cnt_base;
            end
            if (cmd.bld_done)
            begin
                rdy_reg <= 1'b1;
            end
            if (cmd.bld_init)
            begin
                blev_reg <= LEV_W'(1);
                bidx_reg <= '0;
            end
            else if (cmd.bld_wr)
            begin
                if (sts.row_last)
                begin
                    blev_reg <= blev_reg + LEV_W'(1);
                    bidx_reg <= '0;
                end
                else
                begin
                    bidx_reg <= bidx_reg + IDX_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp_max_index   = out_idx_reg;
    assign rsp_range_error = out_err_reg;

endmodule

`default_nettype wire

FILE: rtl/sparse_table_range_max_unit.sv
// sparse table range maximum unit
//
// req channel: req_type selects a load (value, last_element) or a query
// (range_lo, range_hi, inclusive). rsp channel: max_index, range_error,
// one transaction per query and none per load.
// loads are taken one per cycle while no build or query runs. a load
// with last_element set starts the table build, which fills n - 2**k + 1
// entries on every level k >= 1 with 2**k <= n; every table entry costs
// two index reads, two value reads and one write through the same memory
// ports. a valid query passes Q_LEV, Q_TBL (two table reads), Q_VAL (two
// value reads) and Q_CMP (one compare) before its result is registered, and
// no request is taken meanwhile; a rejected query skips Q_TBL and Q_VAL.
// range_error is set for a reversed range, a range past the loaded count,
// or a query with no build since the last load; max_index is then 0.
// reset clears the count, the table ready flag and the controller; memory
// contents are not cleared and no clearing pass runs.
// the result sits in an output register; the next request is taken while
// it waits, but a query that finishes while the receiver stalls holds
// until the register is free.
`default_nettype none

module sparse_table_range_max_unit #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_WIDTH  = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    srm_req_if.sink  req,
    srm_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);

    srm_pkg::srm_cmd_t cmd;
    srm_pkg::srm_sts_t sts;

    srm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_last  (req.last_element),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    srm_dpath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .req_value       (req.value),
        .req_lo          (req.range_lo),
        .req_hi          (req.range_hi),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_max_index   (rsp.max_index),
        .rsp_range_error (rsp.range_error)
    );

endmodule

`default_nettype wire

FILE: rtl/srm_checker.sv
`default_nettype none

module srm_checker #(
    parameter int IDX_W = 10
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire logic             req_type,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire logic [IDX_W-1:0] max_index,
    input wire logic             range_error
);

    logic req_fire;

    assign req_fire = req_valid && req_ready;

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(max_index)
                                    && $stable(range_error))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && range_error |-> max_index == '0)
        else $error("error result with nonzero index");

    // no transaction produces a result in the next cycle
    a_no_fast_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && !rsp_valid |=> !rsp_valid)
        else $error("result too early");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (req_type == srm_pkg::REQ_QUERY) |=> !req_ready)
        else $error("request taken while query in progress");

endmodule

bind sparse_table_range_max_unit srm_checker #(
    .IDX_W (IDX_W)
) u_srm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_type    (req.req_type),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .max_index   (rsp.max_index),
    .range_error (rsp.range_error)
);

`default_nettype wire
